// ----- hdl/tsq_pkg.sv -----
`timescale 1ns / 1ps

package tsq_pkg;

  localparam int ChannelW   = 2;
  localparam int IndexW     = 4;
  localparam int ByteW      = 8;
  localparam int TempW      = 16;
  localparam int CauseW     = 3;
  localparam int CountW     = 8;
  localparam int StepW      = 11;
  localparam int CfgIndexW  = 2;
  localparam int CfgDataW   = 16;
  localparam int DecW       = 12;

  typedef enum logic [CauseW-1:0] {
    CAUSE_NONE     = 3'd0,
    CAUSE_MARKER   = 3'd1,
    CAUSE_CRC      = 3'd2,
    CAUSE_RANGE    = 3'd3,
    CAUSE_POWER_ON = 3'd4
  } cause_t;

  typedef enum logic [CfgIndexW-1:0] {
    CFG_MAX_STEP     = 2'd0,
    CFG_FAIL_LIMIT   = 2'd1,
    CFG_ERROR_MARKER = 2'd2,
    CFG_UNUSED       = 2'd3
  } cfg_index_t;

  localparam logic [IndexW-1:0] BYTE_TEMP_LSB = 4'd0;
  localparam logic [IndexW-1:0] BYTE_TEMP_MSB = 4'd1;
  localparam logic [IndexW-1:0] BYTE_MARKER   = 4'd5;
  localparam logic [IndexW-1:0] BYTE_CRC      = 4'd8;

  localparam logic [ByteW-1:0] MARKER_BYTE   = 8'hFF;
  localparam logic [ByteW-1:0] CRC_POLY      = 8'h18;
  localparam logic [ByteW-1:0] CRC_TOP       = 8'h80;
  localparam logic [4:0]       SIGN_NEG      = 5'h1F;
  localparam logic [4:0]       SIGN_POS      = 5'h00;

  localparam logic signed [DecW-1:0] TEMP_HIGH     = 12'sd1000;
  localparam logic signed [DecW-1:0] TEMP_LOW      = -12'sd550;
  localparam logic signed [DecW-1:0] TEMP_POWER_ON = 12'sd850;

  localparam logic [StepW-1:0]       MAX_STEP_RST     = 11'd20;
  localparam logic [CountW-1:0]      FAIL_LIMIT_RST   = 8'd3;
  localparam logic signed [TempW-1:0] ERROR_MARKER_RST = 16'sh8000;
  localparam logic [CountW-1:0]      COUNT_MAX        = 8'hFF;

endpackage

// ----- hdl/tsq_in_if.sv -----
`timescale 1ns / 1ps

interface tsq_in_if import tsq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ChannelW-1:0] channel;
  logic [IndexW-1:0] byte_index;
  logic [ByteW-1:0]  data;

  modport source (output valid, channel, byte_index, data, input ready);
  modport sink   (input valid, channel, byte_index, data, output ready);
endinterface

// ----- hdl/tsq_out_if.sv -----
`timescale 1ns / 1ps

interface tsq_out_if import tsq_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [ChannelW-1:0]     out_channel;
  logic                    reading_ok;
  logic [CauseW-1:0]       reject_cause;
  logic signed [TempW-1:0] current_temp;
  logic                    sensor_fault;
  logic [CountW-1:0]       fail_count;

  modport source (output valid, out_channel, reading_ok, reject_cause, current_temp,
                  sensor_fault, fail_count, input ready);
  modport sink   (input valid, out_channel, reading_ok, reject_cause, current_temp,
                  sensor_fault, fail_count, output ready);
endinterface

// ----- hdl/tsq_cfg_if.sv -----
`timescale 1ns / 1ps

interface tsq_cfg_if import tsq_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CfgIndexW-1:0] index;
  logic [CfgDataW-1:0]  wdata;

  modport source (output valid, index, wdata, input ready);
  modport sink   (input valid, index, wdata, output ready);
endinterface

// ----- hdl/temperature_sample_qualifier.sv -----
`timescale 1ns / 1ps

// Qualifies thermometer scratchpad reads delivered one byte per item (channel, byte index,
// data). Each item is taken into an input register and handled from there when it advances;
// the block accepts one item every clock as long as results are taken, and an item that
// produces a result stalls only while the result register is still full. Byte 0 restarts
// the CRC, byte 8 yields one result for its channel with the accept/reject cause, the
// filtered temperature in tenths of a degree, the fault flag and the failure count. Items
// with a byte index above 8 are dropped, and byte 8 on a channel not below CHANNELS gives
// no result. A result is written to the result register when its byte 8 item leaves the
// input register and is held there until taken. Configuration writes are taken at any time,
// but must only be issued while no item is in flight.

module temperature_sample_qualifier import tsq_pkg::*; #(
  parameter int CHANNELS = 4,
  parameter int WINDOW   = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  tsq_in_if.sink    in_ch,
  tsq_out_if.source out_ch,
  tsq_cfg_if.sink   cfg_ch
);

  localparam int ChIdxW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int DiffW  = TempW + 1;

  function automatic logic [ByteW-1:0] crc_fold(input logic [ByteW-1:0] crc_in,
                                                input logic [ByteW-1:0] b_in);
    logic [ByteW-1:0] c;
    logic [ByteW-1:0] b;
    c = crc_in;
    b = b_in;
    for (int k = 0; k < ByteW; k++) begin
      if (c[0] ^ b[0]) begin
        c = ((c ^ CRC_POLY) >> 1) | CRC_TOP;
      end else begin
        c = c >> 1;
      end
      b = b >> 1;
    end
    return c;
  endfunction

  // configuration
  logic [StepW-1:0]        max_step_r;
  logic [CountW-1:0]       fail_limit_r;
  logic signed [TempW-1:0] error_marker_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_step_r     <= MAX_STEP_RST;
      fail_limit_r   <= FAIL_LIMIT_RST;
      error_marker_r <= ERROR_MARKER_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_index_t'(cfg_ch.index))
        CFG_MAX_STEP:     max_step_r     <= cfg_ch.wdata[StepW-1:0];
        CFG_FAIL_LIMIT:   fail_limit_r   <= cfg_ch.wdata[CountW-1:0];
        CFG_ERROR_MARKER: error_marker_r <= $signed(cfg_ch.wdata[TempW-1:0]);
        default: ;
      endcase
    end
  end

  // input register
  logic                s1_valid_r;
  logic [ChannelW-1:0] s1_channel_r;
  logic [IndexW-1:0]   s1_index_r;
  logic [ByteW-1:0]    s1_data_r;
  logic                s1_adv;
  logic                s1_result;
  logic                ch_ok;
  logic [ChIdxW-1:0]   ch_idx;

  // result register
  logic                    out_valid_r;
  logic [ChannelW-1:0]     out_channel_r;
  cause_t                  out_cause_r;
  logic signed [TempW-1:0] out_temp_r;
  logic                    out_fault_r;
  logic [CountW-1:0]       out_count_r;

  assign ch_ok     = 32'(s1_channel_r) < CHANNELS;
  assign ch_idx    = ChIdxW'(s1_channel_r);
  assign s1_result = (s1_index_r == BYTE_CRC) && ch_ok;
  assign s1_adv    = s1_valid_r && (!s1_result || !out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_channel_r <= in_ch.channel;
      s1_index_r   <= in_ch.byte_index;
      s1_data_r    <= in_ch.data;
    end
  end

  // scratchpad state
  logic [ByteW-1:0] crc_r;
  logic [ByteW-1:0] low_byte_r;
  logic [ByteW-1:0] high_byte_r;
  logic             marker_good_r;
  logic [ByteW-1:0] crc_nxt;
  logic             byte_in_range;

  assign byte_in_range = s1_index_r <= BYTE_CRC;
  assign crc_nxt = crc_fold((s1_index_r == BYTE_TEMP_LSB) ? '0 : crc_r, s1_data_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r         <= '0;
      marker_good_r <= 1'b0;
    end else if (s1_adv && byte_in_range) begin
      crc_r <= crc_nxt;
      if (s1_index_r == BYTE_MARKER) begin
        marker_good_r <= (s1_data_r == MARKER_BYTE);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_index_r == BYTE_TEMP_LSB) begin
      low_byte_r <= s1_data_r;
    end
    if (s1_adv && s1_index_r == BYTE_TEMP_MSB) begin
      high_byte_r <= s1_data_r;
    end
  end

  // decode to tenths: half degrees times five
  logic [ByteW-1:0]         half_deg;
  logic [4:0]               sign_part;
  logic [ByteW-1:0]         neg_mag;
  logic [DecW-2:0]          pos5;
  logic [DecW-2:0]          neg5;
  logic signed [DecW-1:0]   dec_temp;
  logic signed [TempW-1:0]  dec_temp16;
  cause_t                   cause;

  assign half_deg  = {high_byte_r[2:0], low_byte_r[7:3]};
  assign sign_part = high_byte_r[7:3];
  assign neg_mag   = ~half_deg + 8'd1;
  assign pos5      = {1'b0, half_deg, 2'b00} + {3'b000, half_deg};
  assign neg5      = {1'b0, neg_mag, 2'b00} + {3'b000, neg_mag};

  always_comb begin
    if (sign_part == SIGN_POS) begin
      dec_temp = $signed({1'b0, pos5});
    end else if (sign_part == SIGN_NEG) begin
      dec_temp = -$signed({1'b0, neg5});
    end else begin
      dec_temp = '0;
    end
  end

  assign dec_temp16 = TempW'(dec_temp);

  always_comb begin
    if (!marker_good_r) begin
      cause = CAUSE_MARKER;
    end else if (crc_nxt != '0) begin
      cause = CAUSE_CRC;
    end else if (dec_temp >= TEMP_HIGH || dec_temp < TEMP_LOW) begin
      cause = CAUSE_RANGE;
    end else if (dec_temp == TEMP_POWER_ON) begin
      cause = CAUSE_POWER_ON;
    end else begin
      cause = CAUSE_NONE;
    end
  end

  // per-channel state
  logic signed [TempW-1:0] win_r [CHANNELS][WINDOW];
  logic signed [TempW-1:0] last_temp_r [CHANNELS];
  logic [CountW-1:0]       fail_cnt_r [CHANNELS];
  logic                    fault_r [CHANNELS];

  logic signed [TempW-1:0] win_nxt [WINDOW];
  logic [WINDOW-2:0]       pair_spike;
  logic                    is_marker;
  logic                    win_write;
  logic signed [TempW-1:0] temp_nxt;
  logic [CountW-1:0]       cnt_inc;
  logic [CountW-1:0]       cnt_nxt;
  logic                    fault_nxt;
  logic signed [DiffW-1:0] step_pos;

  assign is_marker = (dec_temp16 == error_marker_r);
  assign step_pos  = $signed({{(DiffW-StepW){1'b0}}, max_step_r});

  always_comb begin
    for (int i = 0; i < WINDOW - 1; i++) begin
      win_nxt[i] = win_r[ch_idx][i + 1];
    end
    win_nxt[WINDOW-1] = dec_temp16;
  end

  always_comb begin
    logic signed [DiffW-1:0] d;
    for (int i = 1; i < WINDOW; i++) begin
      d = DiffW'(win_nxt[i]) - DiffW'(win_nxt[i-1]);
      pair_spike[i-1] = (win_nxt[i] != error_marker_r) && (win_nxt[i-1] != error_marker_r) &&
                        ((d > step_pos) || (d < -step_pos));
    end
  end

  assign cnt_inc = (fail_cnt_r[ch_idx] == COUNT_MAX) ? COUNT_MAX
                                                     : fail_cnt_r[ch_idx] + 8'd1;

  always_comb begin
    win_write = 1'b0;
    temp_nxt  = last_temp_r[ch_idx];
    cnt_nxt   = cnt_inc;
    fault_nxt = fault_r[ch_idx];
    if (cause == CAUSE_NONE) begin
      cnt_nxt   = '0;
      fault_nxt = 1'b0;
      if (is_marker) begin
        temp_nxt = dec_temp16;
      end else begin
        win_write = 1'b1;
        if (pair_spike == '0) begin
          temp_nxt = dec_temp16;
        end
      end
    end else if (cnt_inc > fail_limit_r) begin
      temp_nxt  = error_marker_r;
      fault_nxt = 1'b1;
      cnt_nxt   = fail_limit_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < CHANNELS; c++) begin
        for (int i = 0; i < WINDOW; i++) begin
          win_r[c][i] <= ERROR_MARKER_RST;
        end
        last_temp_r[c] <= '0;
        fail_cnt_r[c]  <= '0;
        fault_r[c]     <= 1'b0;
      end
    end else if (s1_adv && s1_result) begin
      if (win_write) begin
        for (int i = 0; i < WINDOW; i++) begin
          win_r[ch_idx][i] <= win_nxt[i];
        end
      end
      last_temp_r[ch_idx] <= temp_nxt;
      fail_cnt_r[ch_idx]  <= cnt_nxt;
      fault_r[ch_idx]     <= fault_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && s1_result) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_result) begin
      out_channel_r <= s1_channel_r;
      out_cause_r   <= cause;
      out_temp_r    <= temp_nxt;
      out_fault_r   <= fault_nxt;
      out_count_r   <= cnt_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.out_channel  = out_channel_r;
  assign out_ch.reading_ok   = (out_cause_r == CAUSE_NONE);
  assign out_ch.reject_cause = out_cause_r;
  assign out_ch.current_temp = out_temp_r;
  assign out_ch.sensor_fault = out_fault_r;
  assign out_ch.fail_count   = out_count_r;

  // checks
  a_ok_clears_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_cause_r == CAUSE_NONE |-> out_count_r == '0 && !out_fault_r)
    else $error("accepted read left a failure count or fault flag");

  a_stall_holds_item: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && s1_result && out_valid_r && !out_ch.ready
      |=> s1_valid_r && $stable(s1_index_r) && $stable(s1_channel_r) && $stable(s1_data_r))
    else $error("result item overran a full result register");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> in_ch.ready)
    else $error("input stalled with an empty input register");

  a_fault_sets_marker: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && s1_result && cause != CAUSE_NONE && cnt_inc > fail_limit_r
      |=> out_valid_r && out_fault_r && out_temp_r == $past(error_marker_r))
    else $error("fault did not push the error marker");

endmodule
